### rtl/core/iap_pkg.sv
// ----------------------------------------------------------------------------
// iap_pkg
// Shared types, codes and constants of the in-application programming flash
// controller: command and register codes, outcome codes, controller state,
// and the structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package iap_pkg;

  // Default geometry of the flash store.
  localparam int unsigned FlashBytesDef  = 65536;
  localparam int unsigned SectorBytesDef = 512;

  // Width of the flash address registers and of the window bounds.
  localparam int unsigned AddrW = 16;
  localparam int unsigned WinW  = 17;

  // Reset values of the configuration registers.
  localparam logic [7:0]      TrigFirstRst  = 8'h46;
  localparam logic [7:0]      TrigSecondRst = 8'hB9;
  localparam logic [WinW-1:0] WinLowRst     = 17'h02000;
  localparam logic [WinW-1:0] WinHighRst    = 17'h03000;

  // Control register bits.
  localparam int unsigned CtrlEnBit  = 7;
  localparam int unsigned CtrlIspBit = 6;
  localparam int unsigned CtrlArmBit = 5;

  localparam logic [7:0] ErasedByte = 8'hFF;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EOI   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_DATA    = 3'd0,
    REG_ADDR_HI = 3'd1,
    REG_ADDR_LO = 3'd2,
    REG_MODE    = 3'd3,
    REG_TRIG    = 3'd4,
    REG_CTRL    = 3'd5
  } reg_e;

  // Flash operation in the low bits of the mode register.
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_READ  = 2'd1,
    OP_PROG  = 2'd2,
    OP_ERASE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    OUT_NONE    = 3'd0,
    OUT_READ    = 3'd1,
    OUT_PROG    = 3'd2,
    OUT_ERASE   = 3'd3,
    OUT_IGNORED = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    RST_NONE = 2'd0,
    RST_APP  = 2'd1,
    RST_ISP  = 2'd2
  } rst_e;

  // Configuration register index, from paddr[3:2].
  typedef enum logic [1:0] {
    CFG_TRIG_FIRST  = 2'd0,
    CFG_TRIG_SECOND = 2'd1,
    CFG_WIN_LOW     = 2'd2,
    CFG_WIN_HIGH    = 2'd3
  } cfg_idx_e;

  // Memory work that a decoded item asks for.
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_PROG  = 2'd2,
    ACT_ERASE = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_DECODE = 3'd2,
    S_READ   = 3'd3,
    S_PROG   = 3'd4,
    S_ERASE  = 3'd5,
    S_DONE   = 3'd6
  } state_e;

  typedef struct packed {
    logic [7:0]      trig_first;
    logic [7:0]      trig_second;
    logic [WinW-1:0] win_low;
    logic [WinW-1:0] win_high;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic decode;      // apply the item to the registers, form the result
    logic read_done;   // move fetched flash byte into the data register
    logic prog;        // write the programmed byte back
    logic sweep_load;  // point the sweep counter at the sector base
    logic sweep_step;  // write an erased byte, advance the counter
    logic sweep_all;   // the sweep covers the whole store
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    act_e act;
    logic sweep_end;
  } ctrl_sts_t;

endpackage

### rtl/core/iap_ctrl.sv
// ----------------------------------------------------------------------------
// iap_ctrl
// Controller state machine: clears the flash after reset, takes one item at a
// time, and sequences decode, flash read, program and sector erase.
// ----------------------------------------------------------------------------
module iap_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  output logic                  done_o,
  output iap_pkg::ctrl_cmd_t    cmd_o,
  input  iap_pkg::ctrl_sts_t    sts_i
);
  import iap_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_all  = 1'b1;
        if (sts_i.sweep_end) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        unique case (sts_i.act)
          ACT_READ:  state_d = S_READ;
          ACT_PROG:  state_d = S_PROG;
          ACT_ERASE: begin
            cmd_o.sweep_load = 1'b1;
            state_d          = S_ERASE;
          end
          default:   state_d = S_DONE;
        endcase
      end
      S_READ: begin
        cmd_o.read_done = 1'b1;
        state_d         = S_DONE;
      end
      S_PROG: begin
        cmd_o.prog = 1'b1;
        state_d    = S_DONE;
      end
      S_ERASE: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/core/iap_datapath.sv
// ----------------------------------------------------------------------------
// iap_datapath
// Byte registers, trigger sequence check, window checks, the flash store and
// its sweep counter, and the result registers.
// ----------------------------------------------------------------------------
module iap_datapath #(
  parameter int unsigned FLASH_BYTES  = iap_pkg::FlashBytesDef,
  parameter int unsigned SECTOR_BYTES = iap_pkg::SectorBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iap_pkg::cfg_t       cfg_i,
  input  iap_pkg::ctrl_cmd_t  cmd_i,
  output iap_pkg::ctrl_sts_t  sts_o,
  input  logic [1:0]          command_i,
  input  logic [2:0]          reg_offset_i,
  input  logic [7:0]          write_data_i,
  output logic [7:0]          read_data_o,
  output logic [2:0]          outcome_o,
  output logic [1:0]          reset_request_o
);
  import iap_pkg::*;

  localparam int unsigned AW = $clog2(FLASH_BYTES);
  localparam int unsigned SW = $clog2(SECTOR_BYTES);
  localparam logic [WinW-1:0] FlashLim  = WinW'(FLASH_BYTES);
  localparam logic [WinW-1:0] SecSpan   = WinW'(SECTOR_BYTES - 1);
  localparam logic [AW-1:0]   SecMaskIx = AW'(SECTOR_BYTES - 1);

  // Captured item.
  logic [1:0] it_cmd_q, it_cmd_d;
  logic [2:0] it_off_q, it_off_d;
  logic [7:0] it_val_q, it_val_d;

  // Block registers.
  logic [7:0] data_q, data_d;
  logic [7:0] addr_hi_q, addr_hi_d;
  logic [7:0] addr_lo_q, addr_lo_d;
  logic [7:0] mode_q, mode_d;
  logic [7:0] trig_q, trig_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic [7:0] last_trig_q, last_trig_d;
  logic [1:0] kept_q, kept_d;
  rst_e       pend_q, pend_d;

  // Results.
  logic [7:0] res_rd_q, res_rd_d;
  outcome_e   res_out_q, res_out_d;
  rst_e       res_rst_q, res_rst_d;

  // Flash store and sweep counter.
  logic [7:0] mem [FLASH_BYTES];
  logic [7:0] rd_q;
  logic [AW-1:0] cnt_q, cnt_d;

  logic [AddrW-1:0] addr;
  logic [AW-1:0]    addr_ix;
  logic [WinW-1:0]  addr_w, sec_first, sec_last;
  logic             fire;
  outcome_e         exec_out;
  act_e             exec_act;

  function automatic logic in_win(logic [WinW-1:0] a, cfg_t c);
    return (a >= c.win_low) && (a < c.win_high) && (a < FlashLim);
  endfunction

  assign addr      = {addr_hi_q, addr_lo_q};
  assign addr_ix   = addr[AW-1:0];
  assign addr_w    = {1'b0, addr};
  assign sec_first = addr_w & ~SecSpan;
  assign sec_last  = sec_first + SecSpan;

  assign fire = (it_cmd_q == CMD_WRITE) && (it_off_q == REG_TRIG) &&
                (last_trig_q == cfg_i.trig_first) && (it_val_q == cfg_i.trig_second);

  always_comb begin
    exec_out = OUT_NONE;
    exec_act = ACT_NONE;
    if (ctrl_q[CtrlEnBit] && (mode_q[1:0] != OP_IDLE)) begin
      if (!in_win(addr_w, cfg_i)) begin
        exec_out = OUT_IGNORED;
      end else begin
        case (mode_q[1:0])
          OP_READ: begin
            exec_out = OUT_READ;
            exec_act = ACT_READ;
          end
          OP_PROG: begin
            exec_out = OUT_PROG;
            exec_act = ACT_PROG;
          end
          default: begin
            // The whole sector must lie inside the window.
            if (in_win(sec_first, cfg_i) && in_win(sec_last, cfg_i)) begin
              exec_out = OUT_ERASE;
              exec_act = ACT_ERASE;
            end else begin
              exec_out = OUT_IGNORED;
            end
          end
        endcase
      end
    end
  end

  assign sts_o.act       = fire ? exec_act : ACT_NONE;
  assign sts_o.sweep_end = cmd_i.sweep_all ? (&cnt_q) : (&cnt_q[SW-1:0]);

  always_comb begin
    it_cmd_d    = it_cmd_q;
    it_off_d    = it_off_q;
    it_val_d    = it_val_q;
    data_d      = data_q;
    addr_hi_d   = addr_hi_q;
    addr_lo_d   = addr_lo_q;
    mode_d      = mode_q;
    trig_d      = trig_q;
    ctrl_d      = ctrl_q;
    last_trig_d = last_trig_q;
    kept_d      = kept_q;
    pend_d      = pend_q;
    res_rd_d    = res_rd_q;
    res_out_d   = res_out_q;
    res_rst_d   = res_rst_q;
    cnt_d       = cnt_q;

    if (cmd_i.load) begin
      it_cmd_d = command_i;
      it_off_d = reg_offset_i;
      it_val_d = write_data_i;
    end

    if (cmd_i.decode) begin
      res_rd_d  = '0;
      res_out_d = OUT_NONE;
      res_rst_d = RST_NONE;
      unique case (it_cmd_q)
        CMD_WRITE: begin
          unique case (it_off_q)
            REG_DATA:    data_d    = it_val_q;
            REG_ADDR_HI: addr_hi_d = it_val_q;
            REG_ADDR_LO: addr_lo_d = it_val_q;
            REG_MODE:    mode_d    = it_val_q;
            REG_TRIG: begin
              trig_d = it_val_q;
              if (fire) begin
                res_out_d   = exec_out;
                last_trig_d = '0;
              end else begin
                last_trig_d = it_val_q;
              end
            end
            REG_CTRL: begin
              ctrl_d = it_val_q;
              kept_d = it_val_q[7:6];
              if (it_val_q[CtrlArmBit]) begin
                pend_d = it_val_q[CtrlIspBit] ? RST_ISP : RST_APP;
              end
            end
            default: ;
          endcase
        end
        CMD_READ: begin
          unique case (it_off_q)
            REG_DATA:    res_rd_d = data_q;
            REG_ADDR_HI: res_rd_d = addr_hi_q;
            REG_ADDR_LO: res_rd_d = addr_lo_q;
            REG_MODE:    res_rd_d = mode_q;
            REG_TRIG:    res_rd_d = trig_q;
            REG_CTRL:    res_rd_d = ctrl_q;
            default:     res_rd_d = '0;
          endcase
        end
        CMD_EOI: begin
          if (pend_q != RST_NONE) begin
            res_rst_d   = pend_q;
            pend_d      = RST_NONE;
            data_d      = '0;
            addr_hi_d   = '0;
            addr_lo_d   = '0;
            mode_d      = '0;
            trig_d      = '0;
            last_trig_d = '0;
            ctrl_d      = {kept_q, 6'd0};
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.read_done) begin
      data_d = rd_q;
    end

    if (cmd_i.sweep_load) begin
      cnt_d = addr_ix & ~SecMaskIx;
    end else if (cmd_i.sweep_step) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q      <= '0;
      addr_hi_q   <= '0;
      addr_lo_q   <= '0;
      mode_q      <= '0;
      trig_q      <= '0;
      ctrl_q      <= '0;
      last_trig_q <= '0;
      kept_q      <= '0;
      pend_q      <= RST_NONE;
      cnt_q       <= '0;
    end else begin
      data_q      <= data_d;
      addr_hi_q   <= addr_hi_d;
      addr_lo_q   <= addr_lo_d;
      mode_q      <= mode_d;
      trig_q      <= trig_d;
      ctrl_q      <= ctrl_d;
      last_trig_q <= last_trig_d;
      kept_q      <= kept_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_cmd_q  <= it_cmd_d;
    it_off_q  <= it_off_d;
    it_val_q  <= it_val_d;
    res_rd_q  <= res_rd_d;
    res_out_q <= res_out_d;
    res_rst_q <= res_rst_d;
  end

  // The address registers do not change while a flash command runs, so the
  // byte read here is the one a read or program needs in the next cycle.
  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr_ix];
    if (cmd_i.sweep_step) begin
      mem[cnt_q] <= ErasedByte;
    end else if (cmd_i.prog) begin
      mem[addr_ix] <= rd_q & data_q;
    end
  end

  assign read_data_o     = res_rd_q;
  assign outcome_o       = res_out_q;
  assign reset_request_o = res_rst_q;

endmodule

### rtl/core/iap_flash_controller_top.sv
// ----------------------------------------------------------------------------
// iap_flash_controller_top
// In-application programming flash controller with its configuration port.
// ----------------------------------------------------------------------------
// After reset the block is busy while the flash store is swept to FFh, one
// byte per cycle; configuration writes are taken during that time. An item
// is taken when start is high and busy is low, and its result appears for
// exactly one cycle with done_o high; the receiver cannot stall it. The
// controller passes from decode straight to done for a register access or an
// end of instruction, through a read or program state for a flash read or
// program (one registered read of the flash store), and through the erase
// sweep, which writes one byte per cycle, for a sector erase. Busy drops in
// the cycle after the result, so the next item may start then.
// ----------------------------------------------------------------------------
module iap_flash_controller_top #(
  parameter int unsigned FLASH_BYTES  = iap_pkg::FlashBytesDef,
  parameter int unsigned SECTOR_BYTES = iap_pkg::SectorBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Item port
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [2:0]  reg_offset_i,
  input  logic [7:0]  write_data_i,
  // Result port
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic [2:0]  outcome_o,
  output logic [1:0]  reset_request_o
);
  import iap_pkg::*;

  cfg_t      cfg_q, cfg_d;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  cfg_idx_e  cfg_idx;
  logic      cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TRIG_FIRST:  cfg_d.trig_first  = pwdata[7:0];
        CFG_TRIG_SECOND: cfg_d.trig_second = pwdata[7:0];
        CFG_WIN_LOW:     cfg_d.win_low     = pwdata[WinW-1:0];
        CFG_WIN_HIGH:    cfg_d.win_high    = pwdata[WinW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_TRIG_FIRST:  prdata = {24'd0, cfg_q.trig_first};
      CFG_TRIG_SECOND: prdata = {24'd0, cfg_q.trig_second};
      CFG_WIN_LOW:     prdata = {15'd0, cfg_q.win_low};
      CFG_WIN_HIGH:    prdata = {15'd0, cfg_q.win_high};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trig_first  <= TrigFirstRst;
      cfg_q.trig_second <= TrigSecondRst;
      cfg_q.win_low     <= WinLowRst;
      cfg_q.win_high    <= WinHighRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  iap_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  iap_datapath #(
    .FLASH_BYTES  (FLASH_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .command_i       (command_i),
    .reg_offset_i    (reg_offset_i),
    .write_data_i    (write_data_i),
    .read_data_o     (read_data_o),
    .outcome_o       (outcome_o),
    .reset_request_o (reset_request_o)
  );

endmodule

### sim/flash_check_pkg.sv
// ----------------------------------------------------------------------------
// flash_check_pkg
// Scoreboard of the flash controller test: it mirrors the controller's
// registers, trigger logic, soft reset and flash store, turns each accepted
// item into the result it must produce, and checks the results in order.
// ----------------------------------------------------------------------------
package flash_check_pkg;
  import iap_pkg::*;

  localparam int FlashBytes  = iap_pkg::FlashBytesDef;
  localparam int SectorBytes = iap_pkg::SectorBytesDef;

  typedef struct packed {
    logic [7:0] rdata;
    outcome_e   outcome;
    rst_e       rst_req;
  } flash_result_t;

  class flash_scoreboard;
    logic [7:0]      trig_first;
    logic [7:0]      trig_second;
    logic [WinW-1:0] win_low;
    logic [WinW-1:0] win_high;

    logic [7:0] data_q;
    logic [7:0] addr_hi_q;
    logic [7:0] addr_lo_q;
    logic [7:0] mode_q;
    logic [7:0] trig_q;
    logic [7:0] ctrl_q;
    logic [7:0] last_trig_q;
    logic [1:0] kept_ctrl_q;
    rst_e       pending_rst_q;
    logic [7:0] flash_mem [FlashBytes];

    flash_result_t expected_q [$];
    int unsigned   mismatches;

    function new();
      trig_first    = TrigFirstRst;
      trig_second   = TrigSecondRst;
      win_low       = WinLowRst;
      win_high      = WinHighRst;
      data_q        = 8'h00;
      addr_hi_q     = 8'h00;
      addr_lo_q     = 8'h00;
      mode_q        = 8'h00;
      trig_q        = 8'h00;
      ctrl_q        = 8'h00;
      last_trig_q   = 8'h00;
      kept_ctrl_q   = 2'b00;
      pending_rst_q = RST_NONE;
      mismatches    = 0;
      foreach (flash_mem[i]) flash_mem[i] = ErasedByte;
    endfunction

    function void set_config(cfg_idx_e idx, logic [31:0] value);
      case (idx)
        CFG_TRIG_FIRST:  trig_first  = value[7:0];
        CFG_TRIG_SECOND: trig_second = value[7:0];
        CFG_WIN_LOW:     win_low     = value[WinW-1:0];
        CFG_WIN_HIGH:    win_high    = value[WinW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit addr_usable(int a);
      return a >= int'(win_low) && a < int'(win_high) && a < FlashBytes;
    endfunction

    // Flash operation started by a completed trigger pair.
    function outcome_e run_flash_op();
      int   addr;
      int   base_a;
      logic [1:0] op;
      addr = int'({addr_hi_q, addr_lo_q});
      op   = mode_q[1:0];
      if (!ctrl_q[CtrlEnBit] || op == OP_IDLE) return OUT_NONE;
      if (!addr_usable(addr)) return OUT_IGNORED;
      if (op == OP_READ) begin
        data_q = flash_mem[addr];
        return OUT_READ;
      end
      if (op == OP_PROG) begin
        flash_mem[addr] = flash_mem[addr] & data_q;
        return OUT_PROG;
      end
      // An erase must fit entirely inside the window.
      base_a = addr & ~(SectorBytes - 1);
      if (!addr_usable(base_a) || !addr_usable(base_a + SectorBytes - 1)) return OUT_IGNORED;
      for (int i = 0; i < SectorBytes; i++) flash_mem[base_a + i] = ErasedByte;
      return OUT_ERASE;
    endfunction

    function void note_item(logic [1:0] cmd, logic [2:0] off, logic [7:0] wd);
      flash_result_t res;
      res.rdata   = 8'h00;
      res.outcome = OUT_NONE;
      res.rst_req = RST_NONE;
      case (cmd)
        CMD_WRITE: begin
          case (off)
            REG_DATA:    data_q    = wd;
            REG_ADDR_HI: addr_hi_q = wd;
            REG_ADDR_LO: addr_lo_q = wd;
            REG_MODE:    mode_q    = wd;
            REG_TRIG: begin
              trig_q = wd;
              if (last_trig_q == trig_first && wd == trig_second) begin
                res.outcome = run_flash_op();
                last_trig_q = 8'h00;
              end else begin
                last_trig_q = wd;
              end
            end
            REG_CTRL: begin
              ctrl_q      = wd;
              kept_ctrl_q = wd[7:6];
              if (wd[CtrlArmBit]) pending_rst_q = wd[CtrlIspBit] ? RST_ISP : RST_APP;
            end
            default: ;
          endcase
        end
        CMD_READ: begin
          case (off)
            REG_DATA:    res.rdata = data_q;
            REG_ADDR_HI: res.rdata = addr_hi_q;
            REG_ADDR_LO: res.rdata = addr_lo_q;
            REG_MODE:    res.rdata = mode_q;
            REG_TRIG:    res.rdata = trig_q;
            REG_CTRL:    res.rdata = ctrl_q;
            default:     res.rdata = 8'h00;
          endcase
        end
        CMD_EOI: begin
          if (pending_rst_q != RST_NONE) begin
            res.rst_req   = pending_rst_q;
            pending_rst_q = RST_NONE;
            data_q        = 8'h00;
            addr_hi_q     = 8'h00;
            addr_lo_q     = 8'h00;
            mode_q        = 8'h00;
            trig_q        = 8'h00;
            last_trig_q   = 8'h00;
            ctrl_q        = {kept_ctrl_q, 6'b000000};
          end
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [7:0] rdata, logic [2:0] outc, logic [1:0] rq);
      flash_result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected: rdata=%h outcome=%0d reset=%0d",
                                  rdata, outc, rq));
        return;
      end
      exp = expected_q.pop_front();
      if (rdata !== exp.rdata)
        report_mismatch($sformatf("read_data %h, expected %h", rdata, exp.rdata));
      if (outc !== exp.outcome)
        report_mismatch($sformatf("outcome %0d, expected %0d", outc, exp.outcome));
      if (rq !== exp.rst_req)
        report_mismatch($sformatf("reset_request %0d, expected %0d", rq, exp.rst_req));
    endtask
  endclass

endpackage

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the flash controller: configures the trigger bytes and the
// address window over the APB port, sends directed and random register
// transfers, trigger sequences and end-of-instruction events, and checks
// every result against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import iap_pkg::*;
  import flash_check_pkg::*;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam logic [2:0] RegUnusedA = 3'd6;
  localparam logic [2:0] RegUnusedB = 3'd7;
  localparam int         ItemsTarget = 1700;
  localparam int         NumPhases   = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic [2:0]  reg_offset_i;
  logic [7:0]  write_data_i;
  logic        done_o;
  logic [7:0]  read_data_o;
  logic [2:0]  outcome_o;
  logic [1:0]  reset_request_o;

  flash_scoreboard sb;

  logic [7:0] tf_cur;
  logic [7:0] ts_cur;
  int         win_lo_cur;
  int         win_hi_cur;
  int         hot_base;
  int         items_sent;
  int         gap_pct;
  bit         start_hi;

  iap_flash_controller_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .reg_offset_i   (reg_offset_i),
    .write_data_i   (write_data_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .outcome_o      (outcome_o),
    .reset_request_o(reset_request_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(read_data_o, outcome_o, reset_request_o);
  end

  task automatic lower_start();
    if (start_hi) begin
      start    <= 1'b0;
      start_hi = 1'b0;
    end
  endtask

  // Leaves psel high so that transfers can follow back to back.
  task automatic write_cfg(cfg_idx_e idx, logic [31:0] value);
    lower_start();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_config(idx, value);
  endtask

  task automatic apply_cfg(logic [7:0] tf, logic [7:0] ts, int wl, int wh);
    write_cfg(CFG_TRIG_FIRST, 32'(tf));
    write_cfg(CFG_TRIG_SECOND, 32'(ts));
    write_cfg(CFG_WIN_LOW, 32'(wl));
    write_cfg(CFG_WIN_HIGH, 32'(wh));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tf_cur     = tf;
    ts_cur     = ts;
    win_lo_cur = wl;
    win_hi_cur = wh;
    if (wh > wl + 16) hot_base = wl + $urandom_range(0, wh - wl - 16);
    else hot_base = $urandom_range(0, 65520);
  endtask

  task automatic wait_idle();
    lower_start();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_item(logic [1:0] cmd, logic [2:0] off, logic [7:0] wd);
    start        <= 1'b1;
    start_hi     = 1'b1;
    command_i    <= cmd;
    reg_offset_i <= off;
    write_data_i <= wd;
    do @(posedge clk_i); while (busy);
    sb.note_item(cmd, off, wd);
    if (!(cmd == CmdUnused || (cmd == CMD_WRITE && off > REG_CTRL))) items_sent++;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      lower_start();
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [2:0] off, logic [7:0] wd);
    send_item(CMD_WRITE, off, wd);
  endtask

  task automatic fire_trigger();
    write_reg(REG_TRIG, tf_cur);
    write_reg(REG_TRIG, ts_cur);
  endtask

  // Mostly a small pool of addresses so that reads and programs hit the
  // same bytes; the rest probe the window edges or land anywhere.
  function automatic logic [15:0] pick_addr();
    int r;
    int a;
    r = $urandom_range(0, 9);
    case (r)
      6: a = win_lo_cur;
      7: a = win_hi_cur - 1 + $urandom_range(0, 1);
      8: a = win_lo_cur - 1;
      9: a = $urandom_range(0, 65535);
      default: a = hot_base + $urandom_range(0, 15);
    endcase
    return a[15:0];
  endfunction

  task automatic op_sequence();
    logic [15:0] a;
    logic [7:0]  mode_v;
    logic [7:0]  ctrl_v;
    int          r;
    a = pick_addr();
    r = $urandom_range(0, 99);
    mode_v = 8'($urandom_range(0, 255));
    if (r < 40) mode_v[1:0] = OP_READ;
    else if (r < 75) mode_v[1:0] = OP_PROG;
    else if (r < 88) mode_v[1:0] = OP_ERASE;
    else mode_v[1:0] = OP_IDLE;
    if ($urandom_range(0, 3) == 0) begin
      ctrl_v = 8'($urandom_range(0, 255));
      ctrl_v[CtrlEnBit]  = ($urandom_range(0, 99) < 85);
      ctrl_v[CtrlArmBit] = ($urandom_range(0, 7) == 0);
      write_reg(REG_CTRL, ctrl_v);
    end
    write_reg(REG_ADDR_HI, a[15:8]);
    write_reg(REG_ADDR_LO, a[7:0]);
    if (mode_v[1:0] == OP_PROG) write_reg(REG_DATA, 8'($urandom_range(0, 255)));
    write_reg(REG_MODE, mode_v);
    fire_trigger();
    if ($urandom_range(0, 9) < 7) send_item(CMD_READ, REG_DATA, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) == 0) send_item(CMD_EOI, 3'($urandom_range(0, 7)), 8'h00);
  endtask

  task automatic noise_item();
    send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
  endtask

  // A trigger pair split by another transfer, or half of a pair alone.
  task automatic broken_sequence();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_TRIG, tf_cur);
      if ($urandom_range(0, 1) == 0) write_reg(REG_TRIG, 8'($urandom_range(0, 255)));
      else noise_item();
      write_reg(REG_TRIG, ts_cur);
    end else begin
      write_reg(REG_TRIG, ($urandom_range(0, 1) == 0) ? ts_cur : tf_cur);
      noise_item();
    end
  endtask

  initial begin
    int r;
    int phase_end;
    int wl;
    int wh;
    logic [7:0] tv;
    sb           = new();
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    start        = 1'b0;
    start_hi     = 1'b0;
    command_i    = CMD_WRITE;
    reg_offset_i = REG_DATA;
    write_data_i = 8'h00;
    items_sent   = 0;
    gap_pct      = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block accepts configuration while it clears the flash store.
    apply_cfg(TrigFirstRst, TrigSecondRst, int'(WinLowRst), int'(WinHighRst));

    // Directed: one of each operation, then the corner cases.
    write_reg(REG_CTRL, 8'h80);
    write_reg(REG_ADDR_HI, 8'h20);
    write_reg(REG_ADDR_LO, 8'h00);
    write_reg(REG_DATA, 8'h5A);
    write_reg(REG_MODE, {6'b000000, OP_PROG});
    fire_trigger();
    write_reg(REG_MODE, {6'b111111, OP_READ});
    fire_trigger();
    send_item(CMD_READ, REG_DATA, 8'h00);
    write_reg(REG_MODE, {6'b000000, OP_ERASE});
    fire_trigger();
    write_reg(REG_ADDR_HI, 8'hFF);
    write_reg(REG_ADDR_LO, 8'hFF);
    fire_trigger();
    write_reg(REG_CTRL, 8'h00);
    fire_trigger();
    write_reg(RegUnusedB, 8'hFF);
    send_item(CMD_READ, RegUnusedA, 8'h00);
    send_item(CmdUnused, RegUnusedB, 8'hFF);
    write_reg(REG_CTRL, 8'hE0);
    send_item(CMD_EOI, REG_DATA, 8'h00);
    send_item(CMD_READ, REG_CTRL, 8'h00);
    write_reg(REG_CTRL, 8'hA0);
    send_item(CMD_EOI, REG_DATA, 8'h00);
    send_item(CMD_EOI, REG_DATA, 8'h00);

    items_sent = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      case (ph)
        0: apply_cfg(TrigFirstRst, TrigSecondRst, int'(WinLowRst), int'(WinHighRst));
        1: apply_cfg(8'h00, 8'hFF, 0, FlashBytes);
        2: apply_cfg(8'hFF, 8'h00, 'h1234, 'h1300);
        3: apply_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), FlashBytes, 0);
        4: begin
          // Same byte for both halves of the pair, and a random window.
          tv = 8'($urandom_range(0, 255));
          wl = $urandom_range(0, 120) * SectorBytes;
          wh = wl + $urandom_range(1, 16) * SectorBytes;
          if (wh > FlashBytes) wh = FlashBytes;
          apply_cfg(tv, tv, wl, wh);
        end
        default: apply_cfg(TrigFirstRst, TrigSecondRst, FlashBytes - SectorBytes, FlashBytes);
      endcase
      phase_end = ItemsTarget * (ph + 1) / NumPhases;
      while (items_sent < phase_end) begin
        if (items_sent > ItemsTarget * 85 / 100) gap_pct = 0;
        else gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
        r = $urandom_range(0, 99);
        if (r < 70) op_sequence();
        else if (r < 88) noise_item();
        else broken_sequence();
      end
    end

    wait_idle();
    repeat (SectorBytes + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### iap_flash_controller_top.f
rtl/core/iap_pkg.sv
rtl/core/iap_ctrl.sv
rtl/core/iap_datapath.sv
rtl/core/iap_flash_controller_top.sv
sim/flash_check_pkg.sv
sim/tb_top.sv
